/* hdl/cth_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cth_pkg
// Shared types and constants of the co-transition histogram block.
// ----------------------------------------------------------------------------
package cth_pkg;

	localparam int ALPHABET_DEF   = 20;
	localparam int MAX_POINTS_DEF = 8;
	localparam int COUNT_BITS_DEF = 32;

	localparam int LEN_W   = 24;
	localparam int CHAR_W  = 8;
	localparam int CMD_W   = 3;
	localparam int ADDR_W  = 21;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int OUT_CNT_W  = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_POINT  = 3'd0,
		CMD_LOAD_SYMBOL = 3'd1,
		CMD_BRANCH      = 3'd2,
		CMD_COUNT       = 3'd3,
		CMD_READ        = 3'd4
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POINTS = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [7:0]        table_index;
		logic [LEN_W-1:0]  length_value;
		logic [LEN_W-1:0]  length_second;
		logic [4:0]        symbol_code;
		logic              symbol_valid;
		logic [CHAR_W-1:0] first_char_i;
		logic [CHAR_W-1:0] first_char_j;
		logic [CHAR_W-1:0] second_char_i;
		logic [CHAR_W-1:0] second_char_j;
		logic [ADDR_W-1:0] read_address;
	} item_t;

	typedef struct packed {
		logic [OUT_CNT_W-1:0] count_value;
		logic [5:0]           bin_index;
		logic                 bin_valid;
		logic                 counted;
		logic                 saturated;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

endpackage
`default_nettype wire

/* hdl/cth_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cth_stream_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface cth_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/co_transition_histogram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// co_transition_histogram
// Quarter-unit co-transition histogram with quantized branch-length bins.
// ----------------------------------------------------------------------------
// One item is worked at a time. A finished result waits in an output register
// while the next item is taken and worked. The steps of each kind of item:
// - Load and unknown items go straight to the result; a read item first reads
//   the count memory.
// - A count item with no bin held goes straight to the result.
// - Any other count item first looks up four characters, one at a time.
//   With a character outside the alphabet it ends there. Otherwise it
//   does two (edge) or four (cherry) read-modify-writes of the single-port
//   count memory, one after another.
// - A branch item reads the last point, then walks the point table one entry
//   at a time. It stops at the first entry when the length is out of range
//   or falls at the first point; else, at entry k where the walk stops, it
//   picks bin k-1 or k by comparing the squared length with the product of
//   the two points around it.
// A result that is not taken holds the block in its last cycle. After reset
// a clearing pass writes zero to every one of the MAX_POINTS * ALPHABET^4
// cells (1280000 at the defaults), one per cycle, and the 256 entries of the
// symbol map are swept too; no item is taken until both are done.
module co_transition_histogram #(
	parameter int ALPHABET   = cth_pkg::ALPHABET_DEF,
	parameter int MAX_POINTS = cth_pkg::MAX_POINTS_DEF,
	parameter int COUNT_BITS = cth_pkg::COUNT_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cth_stream_if.sink   in_ch,
	cth_stream_if.sink   cfg,
	cth_stream_if.source out_ch
);
	import cth_pkg::*;

	localparam int PAIRS    = ALPHABET * ALPHABET;
	localparam int BCELLS   = PAIRS * PAIRS;
	localparam int CELLS    = MAX_POINTS * BCELLS;
	localparam int CW       = $clog2(CELLS);
	localparam int RW       = $clog2(ALPHABET);
	localparam int PW       = $clog2(PAIRS);
	localparam int BW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NW       = $clog2(MAX_POINTS + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_SYM_RD, ST_SYM_CHK, ST_BR_SUM, ST_BR_TOP, ST_BR_RD,
		ST_BR_CMP, ST_BR_MUL, ST_BR_DEC, ST_CNT_RD, ST_CNT_WR, ST_RD_WAIT, ST_RD_OUT,
		ST_DONE
	} state_t;

	state_t state_q;
	item_t  item_q;
	logic   mode_q;
	logic [CFG_DATA_W-1:0] points_q;

	// Memories.
	logic [LEN_W-1:0]      point_mem [MAX_POINTS];
	logic [5:0]            sym_mem [256];
	logic [COUNT_BITS-1:0] cnt_mem [CELLS];
	logic [LEN_W-1:0]      pt_rd_q;
	logic [5:0]            sym_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;

	logic [7:0]  sym_addr;
	logic        sym_we;
	logic [5:0]  sym_wd;
	logic [BW-1:0] pt_addr;
	logic [CW-1:0] cnt_addr;
	logic        cnt_we;
	logic [COUNT_BITS-1:0] cnt_wd;

	// Clear sweep and sequencing registers.
	logic [CW-1:0] clr_q;
	logic [7:0]    sclr_q;
	logic          sclr_done_q;
	logic [1:0]    sub_q;
	logic [RW-1:0] res_q [4];
	logic          res_ok_q;
	logic [CW-1:0] cell_q [4];
	logic          hit_q;
	logic [1:0]    last_q;

	// Branch state.
	logic [LEN_W:0]  len_q;
	logic [NW-1:0]   k_q;
	logic [LEN_W-1:0] lo_q, hi_q, top_q;
	logic [2*LEN_W+1:0] lsq_q, prod_q;
	logic            bin_v_q;
	logic [5:0]      bin_q;

	result_t res_out_q;
	logic    out_v_q;
	logic [OUT_CNT_W-1:0] cval_q;

	logic [NW-1:0] n_act;
	always_comb begin
		if (points_q == '0) begin
			n_act = NW'(1);
		end else if (32'(points_q) > MAX_POINTS) begin
			n_act = NW'(MAX_POINTS);
		end else begin
			n_act = NW'(points_q);
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE) && sclr_done_q;
	assign cfg.ready   = 1'b1;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = res_out_q;

	// Memory address selection.
	always_comb begin
		sym_addr = sclr_done_q ? item_q.table_index : sclr_q;
		sym_we   = !sclr_done_q;
		sym_wd   = '0;
		if (state_q == ST_SYM_RD) begin
			unique case (sub_q)
				2'd0: sym_addr = item_q.first_char_i;
				2'd1: sym_addr = item_q.first_char_j;
				2'd2: sym_addr = item_q.second_char_i;
				default: sym_addr = item_q.second_char_j;
			endcase
		end
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready
			&& in_ch.data.command == CMD_LOAD_SYMBOL) begin
			sym_addr = in_ch.data.table_index;
			sym_we   = 1'b1;
			sym_wd   = in_ch.data.symbol_valid ? {1'b1, in_ch.data.symbol_code} : 6'd0;
		end
	end

	// The last point in use is read first so the range check does not depend
	// on the table being sorted.
	assign pt_addr = (state_q == ST_BR_SUM) ? BW'(n_act - NW'(1)) : BW'(k_q);

	logic [COUNT_BITS:0] cnt_sum;
	logic [COUNT_BITS-1:0] cnt_new;
	logic [1:0] weight;
	assign weight  = mode_q ? 2'd1 : 2'd2;
	assign cnt_sum = {1'b0, cnt_rd_q} + (COUNT_BITS+1)'(weight);
	assign cnt_new = cnt_sum[COUNT_BITS] ? CMAX : cnt_sum[COUNT_BITS-1:0];

	always_comb begin
		cnt_we   = 1'b0;
		cnt_wd   = '0;
		cnt_addr = clr_q;
		unique case (state_q)
			ST_CLEAR: begin
				cnt_we = 1'b1;
			end
			ST_CNT_RD: begin
				cnt_addr = cell_q[sub_q];
			end
			ST_CNT_WR: begin
				cnt_addr = cell_q[sub_q];
				cnt_we   = 1'b1;
				cnt_wd   = cnt_new;
			end
			ST_RD_WAIT: begin
				cnt_addr = CW'(item_q.read_address);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sym_we) begin
			sym_mem[sym_addr] <= sym_wd;
		end
		sym_rd_q <= sym_mem[sym_addr];
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready
			&& in_ch.data.command == CMD_LOAD_POINT && 32'(in_ch.data.table_index) < MAX_POINTS) begin
			point_mem[BW'(in_ch.data.table_index)] <= in_ch.data.length_value;
		end
		pt_rd_q <= point_mem[pt_addr];
		if (cnt_we) begin
			cnt_mem[cnt_addr] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[cnt_addr];
	end

	// Cell index arithmetic from four residues.
	logic [PW-1:0] pr_s, pr_e, pr_sr, pr_er;
	logic [CW-1:0] base;
	always_comb begin
		pr_s  = PW'(res_q[0] * ALPHABET) + PW'(res_q[1]);
		pr_e  = PW'(res_q[2] * ALPHABET) + PW'(res_q[3]);
		pr_sr = PW'(res_q[1] * ALPHABET) + PW'(res_q[0]);
		pr_er = PW'(res_q[3] * ALPHABET) + PW'(res_q[2]);
		base  = CW'(bin_q * BCELLS);
	end

	logic res_good;
	assign res_good = sym_rd_q[5] && (32'(sym_rd_q[4:0]) < ALPHABET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sclr_q      <= '0;
			sclr_done_q <= 1'b0;
			mode_q      <= 1'b0;
			points_q    <= CFG_DATA_W'(1);
			bin_v_q     <= 1'b0;
			bin_q       <= '0;
			out_v_q     <= 1'b0;
			sub_q       <= '0;
		end else begin
			if (cfg.valid) begin
				if (cfg.data.index == REG_MODE) begin
					mode_q <= cfg.data.data[0];
				end else begin
					points_q <= cfg.data.data;
				end
			end
			if (state_q == ST_DONE && (!out_v_q || out_ch.ready)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (!sclr_done_q) begin
				sclr_q <= sclr_q + 8'd1;
				if (sclr_q == 8'hFF) begin
					sclr_done_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (32'(clr_q) == CELLS - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready && sclr_done_q) begin
						item_q   <= in_ch.data;
						sub_q    <= '0;
						hit_q    <= 1'b0;
						res_ok_q <= 1'b1;
						unique case (in_ch.data.command)
							CMD_BRANCH: state_q <= ST_BR_SUM;
							CMD_COUNT: state_q <= bin_v_q ? ST_SYM_RD : ST_DONE;
							CMD_READ: state_q <= ST_RD_WAIT;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SYM_RD: begin
					state_q <= ST_SYM_CHK;
				end
				ST_SYM_CHK: begin
					res_q[sub_q] <= sym_rd_q[RW-1:0];
					if (!res_good) begin
						res_ok_q <= 1'b0;
					end
					if (sub_q == 2'd3) begin
						sub_q   <= '0;
						state_q <= (res_ok_q && res_good) ? ST_BR_DEC : ST_DONE;
						last_q  <= mode_q ? 2'd3 : 2'd1;
					end else begin
						sub_q   <= sub_q + 2'd1;
						state_q <= ST_SYM_RD;
					end
				end
				ST_BR_DEC: begin
					// Build the cell list in update order.
					cell_q[0] <= base + CW'(pr_s * PAIRS) + CW'(pr_e);
					if (mode_q) begin
						cell_q[1] <= base + CW'(pr_e * PAIRS) + CW'(pr_s);
						cell_q[2] <= base + CW'(pr_sr * PAIRS) + CW'(pr_er);
						cell_q[3] <= base + CW'(pr_er * PAIRS) + CW'(pr_sr);
					end else begin
						cell_q[1] <= base + CW'(pr_sr * PAIRS) + CW'(pr_er);
					end
					state_q <= ST_CNT_RD;
				end
				ST_CNT_RD: begin
					state_q <= ST_CNT_WR;
				end
				ST_CNT_WR: begin
					if (cnt_new == CMAX) begin
						hit_q <= 1'b1;
					end
					if (sub_q == last_q) begin
						state_q <= ST_DONE;
					end else begin
						sub_q   <= sub_q + 2'd1;
						state_q <= ST_CNT_RD;
					end
				end
				ST_BR_SUM: begin
					len_q <= {1'b0, item_q.length_value}
						+ (mode_q ? {1'b0, item_q.length_second} : '0);
					k_q     <= '0;
					state_q <= ST_BR_TOP;
				end
				ST_BR_TOP: begin
					top_q   <= pt_rd_q;
					state_q <= ST_BR_CMP;
				end
				ST_BR_RD: begin
					state_q <= ST_BR_CMP;
				end
				ST_BR_CMP: begin
					hi_q <= pt_rd_q;
					lo_q <= hi_q;
					if (k_q == '0 && (len_q < {1'b0, pt_rd_q} || len_q > {1'b0, top_q})) begin
						bin_v_q <= 1'b0;
						state_q <= ST_DONE;
					end else if (k_q == n_act - NW'(1) || len_q <= {1'b0, pt_rd_q}) begin
						if (k_q == '0) begin
							bin_v_q <= 1'b1;
							bin_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_BR_MUL;
						end
					end else begin
						k_q     <= k_q + NW'(1);
						state_q <= ST_BR_RD;
					end
				end
				ST_BR_MUL: begin
					lsq_q   <= (2*LEN_W+2)'(len_q * len_q);
					prod_q  <= (2*LEN_W+2)'(lo_q * hi_q);
					state_q <= ST_RD_OUT;
				end
				ST_RD_WAIT: begin
					state_q <= ST_RD_OUT;
				end
				ST_RD_OUT: begin
					if (item_q.command == CMD_BRANCH) begin
						bin_v_q <= 1'b1;
						bin_q   <= (lsq_q < prod_q) ? 6'(k_q - NW'(1)) : 6'(k_q);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_v_q || out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic is_cnt;
	assign is_cnt = (item_q.command == CMD_COUNT) && bin_v_q && res_ok_q;

	// The read value is staged so that a result still waiting is not touched.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
			cval_q <= '0;
		end
		if (state_q == ST_RD_OUT && item_q.command == CMD_READ) begin
			cval_q <= (32'(item_q.read_address) < CELLS) ? OUT_CNT_W'(cnt_rd_q) : '0;
		end
		if (state_q == ST_DONE && (!out_v_q || out_ch.ready)) begin
			res_out_q.count_value <= cval_q;
			res_out_q.bin_index   <= bin_v_q ? bin_q : '0;
			res_out_q.bin_valid   <= bin_v_q;
			res_out_q.counted     <= is_cnt;
			res_out_q.saturated   <= is_cnt && hit_q;
		end
	end

	property p_no_take_while_busy;
		@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready;
	endproperty
	a_no_take_while_busy: assert property (p_no_take_while_busy)
		else $error("input taken while an item is in progress");

	property p_sat_implies_counted;
		@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (!res_out_q.saturated || res_out_q.counted);
	endproperty
	a_sat_implies_counted: assert property (p_sat_implies_counted)
		else $error("saturated without count");

	property p_bin_range;
		@(posedge clk) disable iff (!arst_n)
		bin_v_q |-> (32'(bin_q) < MAX_POINTS);
	endproperty
	a_bin_range: assert property (p_bin_range)
		else $error("bin out of range");

endmodule
`default_nettype wire
